FILE: sv/upds_pkg.sv
// Shared types and constants for the up/down potentiometer wiper sequencer.
package upds_pkg;

    localparam int STEP_W = 7;
    localparam int EXTRA_W = 4;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_GOTO   = 2'd1,
        ACT_SWEEP  = 2'd2,
        ACT_TO_MAX = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTRA_TOP    = 3'd0,
        REG_EXTRA_BOTTOM = 3'd1,
        REG_INVERT_DIR   = 3'd2,
        REG_RISE_ONLY    = 3'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_MOVE        = 3'd1,
        PH_ANCHOR_LOW  = 3'd2,
        PH_ANCHOR_HIGH = 3'd3,
        PH_SWEEP       = 3'd4,
        PH_SWEEP_IDLE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [EXTRA_W-1:0] extra_top;
        logic [EXTRA_W-1:0] extra_bottom;
        logic               invert_dir;
        logic               rise_only;
    } upds_cfg_t;

    typedef struct packed {
        logic [STEP_W-1:0] wiper_count;
        logic              anchor_low;
        logic              anchor_high;
        logic              inc_high;
        logic [STEP_W-1:0] goal_step;
        phase_t            phase;
        logic [STEP_W-1:0] pulse_count;
        logic              pulse_half;
        logic              last_dir_up;
    } upds_state_t;

    typedef struct packed {
        logic              chip_select_level;
        logic              increment_level;
        logic              direction_level;
        logic              busy_res;
        logic [STEP_W-1:0] wiper_position;
        logic              anchored_low;
        logic              anchored_high;
        logic              command_rejected;
    } upds_result_t;

endpackage

FILE: sv/upds_engine.sv
// Wiper sequencing state and the per-tick next-state and pin logic.
module upds_engine #(
    parameter int MAX_STEP = 99
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [1:0]                  action,
    input  logic [upds_pkg::STEP_W-1:0] target_step,
    input  upds_pkg::upds_cfg_t         cfg,
    output upds_pkg::upds_result_t      result
);
    import upds_pkg::*;

    localparam logic [STEP_W-1:0] MaxStep = STEP_W'(MAX_STEP);

    upds_state_t st_reg;
    upds_state_t st_next;

    function automatic upds_state_t begin_anchor(upds_state_t s, logic low,
                                                 upds_cfg_t c);
        logic [EXTRA_W-1:0] n;
        n = low ? c.extra_bottom : c.extra_top;
        if (n == '0)
        begin
            s.anchor_low  = low;
            s.anchor_high = !low;
            s.phase       = PH_IDLE;
        end
        else
        begin
            s.pulse_count = STEP_W'(n);
            s.pulse_half  = 1'b0;
            s.phase       = low ? PH_ANCHOR_LOW : PH_ANCHOR_HIGH;
        end
        return s;
    endfunction

    function automatic upds_state_t pulse_done(upds_state_t s, upds_cfg_t c);
        case (s.phase)
            PH_MOVE:
            begin
                // The first step away from an anchored extreme is not counted.
                if (s.last_dir_up)
                begin
                    if (s.anchor_low)
                        s.anchor_low = 1'b0;
                    else
                    begin
                        if (s.wiper_count < MaxStep)
                            s.wiper_count = s.wiper_count + 1'b1;
                        s.anchor_high = 1'b0;
                    end
                end
                else
                begin
                    if (s.anchor_high)
                        s.anchor_high = 1'b0;
                    else
                    begin
                        if (s.wiper_count != '0)
                            s.wiper_count = s.wiper_count - 1'b1;
                        s.anchor_low = 1'b0;
                    end
                end
                if (s.wiper_count == s.goal_step)
                begin
                    if (s.goal_step == '0)
                        s = begin_anchor(s, 1'b1, c);
                    else if (s.goal_step == MaxStep)
                        s = begin_anchor(s, 1'b0, c);
                    else
                    begin
                        s.anchor_low  = 1'b0;
                        s.anchor_high = 1'b0;
                        s.phase       = PH_IDLE;
                    end
                end
            end
            PH_ANCHOR_LOW, PH_ANCHOR_HIGH:
            begin
                if (s.pulse_count <= STEP_W'(1))
                begin
                    s.anchor_low  = (s.phase == PH_ANCHOR_LOW);
                    s.anchor_high = (s.phase == PH_ANCHOR_HIGH);
                    s.pulse_count = '0;
                    s.phase       = PH_IDLE;
                end
                else
                    s.pulse_count = s.pulse_count - 1'b1;
            end
            PH_SWEEP:
            begin
                if (s.pulse_count == '0)
                begin
                    s.wiper_count = '0;
                    s.phase       = PH_SWEEP_IDLE;
                end
                else
                    s.pulse_count = s.pulse_count - 1'b1;
            end
            default:
                s.phase = PH_IDLE;
        endcase
        return s;
    endfunction

    function automatic upds_state_t start_goto(upds_state_t s,
                                               logic [STEP_W-1:0] t_in,
                                               upds_cfg_t c);
        logic [STEP_W-1:0] t;
        t = (t_in > MaxStep) ? MaxStep : t_in;
        if (t == s.wiper_count)
        begin
            if (t == '0 && !s.anchor_low)
                s = begin_anchor(s, 1'b1, c);
            else if (t == MaxStep && !s.anchor_high)
                s = begin_anchor(s, 1'b0, c);
        end
        else
        begin
            s.goal_step  = t;
            s.pulse_half = 1'b0;
            s.phase      = PH_MOVE;
        end
        return s;
    endfunction

    always_comb
    begin
        st_next = st_reg;
        result  = '0;
        result.chip_select_level = 1'b1;

        // Command decode: a command acts in the same tick it is accepted.
        if (st_reg.phase != PH_IDLE)
            result.command_rejected = (action != ACT_TICK);
        else
        begin
            case (action)
                ACT_GOTO:   st_next = start_goto(st_next, target_step, cfg);
                ACT_TO_MAX: st_next = start_goto(st_next, MaxStep, cfg);
                ACT_SWEEP:
                begin
                    st_next.pulse_count = MaxStep;
                    st_next.pulse_half  = 1'b0;
                    st_next.phase       = PH_SWEEP;
                end
                default: ;
            endcase
        end

        if (st_next.phase != PH_IDLE)
        begin
            result.busy_res = 1'b1;
            if (st_next.phase == PH_SWEEP_IDLE)
            begin
                result.chip_select_level = 1'b1;
                result.increment_level   = 1'b0;
                st_next.inc_high = 1'b0;
                st_next = begin_anchor(st_next, 1'b1, cfg);
            end
            else if (st_next.pulse_half)
            begin
                // Trailing low half of a full pulse.
                result.chip_select_level = 1'b0;
                result.increment_level   = 1'b0;
                st_next.pulse_half = 1'b0;
                st_next.inc_high   = 1'b0;
                st_next = pulse_done(st_next, cfg);
            end
            else if (st_next.inc_high)
            begin
                // Preparation tick that lowers increment before the next rise.
                result.chip_select_level = 1'b1;
                result.increment_level   = 1'b0;
                st_next.inc_high = 1'b0;
            end
            else
            begin
                if (st_next.phase == PH_MOVE)
                    st_next.last_dir_up = (st_next.wiper_count < st_next.goal_step);
                else
                    st_next.last_dir_up = (st_next.phase == PH_ANCHOR_HIGH);
                result.chip_select_level = 1'b0;
                result.increment_level   = 1'b1;
                st_next.inc_high = 1'b1;
                if (cfg.rise_only)
                    st_next = pulse_done(st_next, cfg);
                else
                    st_next.pulse_half = 1'b1;
            end
        end
        else
        begin
            result.chip_select_level = 1'b1;
            result.increment_level   = st_next.inc_high;
        end

        result.direction_level = st_next.last_dir_up ^ cfg.invert_dir;
        result.wiper_position  = st_next.wiper_count;
        result.anchored_low    = st_next.anchor_low;
        result.anchored_high   = st_next.anchor_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '{phase: PH_IDLE, default: '0};
        else if (step)
            st_reg <= st_next;
    end

endmodule

FILE: sv/updown_pot_wiper_sequencer_core.sv
// Top level of the up/down potentiometer wiper sequencer: handshakes, registers, result stage.
// Result: an accepted input transaction's result appears in the output register in the next cycle.
// Throughput: one transaction per cycle; the single output register stalls input only while
// its result is held by the downstream stall.
// Reset: wiper count, anchor flags and sequence state clear to idle at step zero; all
// configuration registers clear to zero; no result is pending after reset.
module updown_pot_wiper_sequencer_core #(
    parameter int MAX_STEP = 99
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [upds_pkg::STEP_W-1:0]    target_step,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           chip_select_level,
    output logic                           increment_level,
    output logic                           direction_level,
    output logic                           busy_res,
    output logic [upds_pkg::STEP_W-1:0]    wiper_position,
    output logic                           anchored_low,
    output logic                           anchored_high,
    output logic                           command_rejected,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [upds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [upds_pkg::EXTRA_W-1:0]   cfg_data
);
    import upds_pkg::*;

    upds_cfg_t    cfg_reg;
    upds_result_t res_comb;
    upds_result_t res_reg;
    logic         out_valid_reg;
    logic         in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXTRA_TOP:    cfg_reg.extra_top    <= cfg_data;
                REG_EXTRA_BOTTOM: cfg_reg.extra_bottom <= cfg_data;
                REG_INVERT_DIR:   cfg_reg.invert_dir   <= cfg_data[0];
                REG_RISE_ONLY:    cfg_reg.rise_only    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    upds_engine #(
        .MAX_STEP (MAX_STEP)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_accept),
        .action      (action),
        .target_step (target_step),
        .cfg         (cfg_reg),
        .result      (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_comb;
    end

    assign out_valid         = out_valid_reg;
    assign chip_select_level = res_reg.chip_select_level;
    assign increment_level   = res_reg.increment_level;
    assign direction_level   = res_reg.direction_level;
    assign busy_res          = res_reg.busy_res;
    assign wiper_position    = res_reg.wiper_position;
    assign anchored_low      = res_reg.anchored_low;
    assign anchored_high     = res_reg.anchored_high;
    assign command_rejected  = res_reg.command_rejected;

endmodule
